// ===== hdl/tccc_pkg.sv =====
package tccc_pkg;

  // Result slots of one queued command, in the order they leave the block.
  typedef enum logic [2:0] {
    SLOT_START_POLL  = 3'd0,
    SLOT_SCROLL      = 3'd1,
    SLOT_SCROLL_POLL = 3'd2,
    SLOT_COL1        = 3'd3,
    SLOT_ROW1        = 3'd4,
    SLOT_CHAR        = 3'd5,
    SLOT_COL2        = 3'd6,
    SLOT_ROW2        = 3'd7
  } slot_t;

  localparam int unsigned NUM_SLOTS = 8;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_BASE    = 2'd0,
    CFG_COLUMNS = 2'd1,
    CFG_ROWS    = 2'd2
  } cfg_idx_t;

  localparam int unsigned CFG_IDX_W = 2;

  // Input operations.
  localparam logic OP_PRINT = 1'b0;
  localparam logic OP_SET   = 1'b1;

  // Output actions.
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_POLL  = 1'b1;

  // Display register offsets.
  localparam logic [31:0] OFS_ROW    = 32'h0000_0001;
  localparam logic [31:0] OFS_COL    = 32'h0000_0002;
  localparam logic [31:0] OFS_SCROLL = 32'h0000_0005;
  localparam logic [31:0] OFS_CHAR   = 32'h0000_0010;

  localparam logic [7:0] READY_STATUS = 8'h10;
  localparam logic [7:0] CH_BACKSPACE = 8'h01;
  localparam logic [7:0] CH_NEWLINE   = 8'h0a;
  localparam logic [7:0] CH_BLANK     = 8'h20;
  localparam logic [7:0] SCROLL_DATA  = 8'h01;

  localparam logic [7:0] COLUMNS_RESET = 8'd21;
  localparam logic [7:0] ROWS_RESET    = 8'd8;

  localparam int unsigned QUEUE_DEPTH = 4;

  // One classified item: which result slots fire and the bytes they carry.
  typedef struct packed {
    logic [NUM_SLOTS-1:0] slots;
    logic [7:0]           col1;
    logic [7:0]           row1;
    logic [7:0]           chr;
    logic [7:0]           col2;
    logic [7:0]           row2;
  } cmd_t;

endpackage

// ===== hdl/text_console_cursor_controller.sv =====
// Text console cursor controller. Each input transfer is one character of a
// string (op 0) or a set-cursor request (op 1); the block tracks the cursor
// column and row and turns the item into up to eight output transfers, each a
// byte write to display_base plus a register offset (tuser 0) or a wait that
// polls display_base until the status reads 0x10 (tuser 1). out_tlast marks
// the last output transfer of an item; an item that causes nothing (character
// code zero with no string flags) gives no output at all. The cursor is
// updated at input accept, so a new item can be taken every cycle while the
// command queue has room. The output side then produces one transfer per
// clock while out_tready does not stall it; an item has one to eight
// results (two for set-cursor).
// Write configuration only while the block is idle.
module text_console_cursor_controller #(
  parameter int unsigned QUEUE_DEPTH = tccc_pkg::QUEUE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration write port
  input  logic                           cfg_we,
  input  logic [tccc_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [31:0]                    cfg_wdata,
  // input stream
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // [7:0] char_code, [8] string_start, [16:9] target_column,
  // [24:17] target_row, [31:25] zero
  input  logic [31:0]                    in_tdata,
  input  logic                           in_tuser,   // [0] op
  input  logic                           in_tlast,   // string_end
  // result stream
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [31:0] bus_address, [39:32] write_data
  output logic [39:0]                    out_tdata,
  output logic                           out_tuser,  // [0] action
  output logic                           out_tlast   // final_res
);

  logic [31:0] base_r;
  logic [7:0]  columns_r;
  logic [7:0]  rows_r;

  // Configuration registers: hold until written, ignore unknown indexes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r    <= '0;
      columns_r <= tccc_pkg::COLUMNS_RESET;
      rows_r    <= tccc_pkg::ROWS_RESET;
    end else if (cfg_we) begin
      unique case (tccc_pkg::cfg_idx_t'(cfg_addr))
        tccc_pkg::CFG_BASE:    base_r    <= cfg_wdata;
        tccc_pkg::CFG_COLUMNS: columns_r <= cfg_wdata[7:0];
        tccc_pkg::CFG_ROWS:    rows_r    <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  logic           q_full;
  logic           q_not_empty;
  logic           q_push;
  logic           q_pop;
  tccc_pkg::cmd_t q_in_cmd;
  tccc_pkg::cmd_t q_head;

  logic           res_action;
  logic [31:0]    res_addr;
  logic [7:0]     res_data;
  logic           res_final;

  // Accept whenever the queue has a free entry.
  assign in_tready = !q_full;

  // Front: classify the item, advance the cursor, build the command.
  tccc_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_tvalid),
    .q_ready       (in_tready),
    .op            (in_tuser),
    .char_code     (in_tdata[7:0]),
    .string_start  (in_tdata[8]),
    .string_end    (in_tlast),
    .target_column (in_tdata[16:9]),
    .target_row    (in_tdata[24:17]),
    .columns       (columns_r),
    .rows          (rows_r),
    .push          (q_push),
    .cmd           (q_in_cmd)
  );

  // Queue: decouple classification from bus-action sequencing.
  tccc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (q_in_cmd),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  // Back: walk the pending slots of each command, one transfer per cycle unless stalled.
  tccc_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .display_base (base_r),
    .q_not_empty  (q_not_empty),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .action       (res_action),
    .bus_address  (res_addr),
    .write_data   (res_data),
    .final_res    (res_final)
  );

  assign out_tdata = {res_data, res_addr};
  assign out_tuser = res_action;
  assign out_tlast = res_final;

endmodule

// ===== hdl/tccc_front.sv =====
module tccc_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              q_ready,
  input  logic              op,
  input  logic [7:0]        char_code,
  input  logic              string_start,
  input  logic              string_end,
  input  logic [7:0]        target_column,
  input  logic [7:0]        target_row,
  input  logic [7:0]        columns,
  input  logic [7:0]        rows,
  output logic              push,
  output tccc_pkg::cmd_t    cmd
);

  logic [7:0] col_r, col_nxt;
  logic [7:0] row_r, row_nxt;
  logic [7:0] max_col, max_row;
  logic       accept;

  assign max_col = columns - 8'd1;
  assign max_row = rows - 8'd1;
  assign accept  = in_valid && q_ready;

  always_comb begin
    logic [7:0] c;
    logic [7:0] r;
    c   = col_r;
    r   = row_r;
    cmd = '0;
    if (op == tccc_pkg::OP_SET) begin
      c = (target_column >= columns) ? max_col : target_column;
      r = (target_row >= rows) ? max_row : target_row;
      cmd.slots[tccc_pkg::SLOT_COL1] = 1'b1;
      cmd.slots[tccc_pkg::SLOT_ROW1] = 1'b1;
      cmd.col1 = c;
      cmd.row1 = r;
    end else begin
      cmd.slots[tccc_pkg::SLOT_START_POLL] = string_start;
      if (char_code == tccc_pkg::CH_BACKSPACE) begin
        if (c != 8'd0) begin
          c = c - 8'd1;
          cmd.slots[tccc_pkg::SLOT_COL1] = 1'b1;
          cmd.slots[tccc_pkg::SLOT_CHAR] = 1'b1;
          cmd.col1 = c;
          cmd.chr  = tccc_pkg::CH_BLANK;
        end
      end else if (char_code == tccc_pkg::CH_NEWLINE) begin
        c = 8'd0;
        if (r < max_row) begin
          r = r + 8'd1;
        end else begin
          cmd.slots[tccc_pkg::SLOT_SCROLL]      = 1'b1;
          cmd.slots[tccc_pkg::SLOT_SCROLL_POLL] = 1'b1;
        end
      end else if (char_code != 8'd0) begin
        // wrap at the line width, scrolling on the last row
        if (c >= columns) begin
          c = 8'd0;
          if (r < max_row) begin
            r = r + 8'd1;
          end else begin
            cmd.slots[tccc_pkg::SLOT_SCROLL]      = 1'b1;
            cmd.slots[tccc_pkg::SLOT_SCROLL_POLL] = 1'b1;
          end
        end
        cmd.slots[tccc_pkg::SLOT_COL1] = 1'b1;
        cmd.slots[tccc_pkg::SLOT_ROW1] = 1'b1;
        cmd.slots[tccc_pkg::SLOT_CHAR] = 1'b1;
        cmd.col1 = c;
        cmd.row1 = r;
        cmd.chr  = char_code;
        c = c + 8'd1;
      end
      if (string_end) begin
        cmd.slots[tccc_pkg::SLOT_COL2] = 1'b1;
        cmd.slots[tccc_pkg::SLOT_ROW2] = 1'b1;
        cmd.col2 = c;
        cmd.row2 = r;
      end
    end
    col_nxt = accept ? c : col_r;
    row_nxt = accept ? r : row_r;
  end

  // items that cause no result are dropped here
  assign push = accept && (cmd.slots != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= 8'd0;
      row_r <= 8'd0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

// ===== hdl/tccc_queue.sv =====
module tccc_queue #(
  parameter int unsigned DEPTH = tccc_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  tccc_pkg::cmd_t push_cmd,
  input  logic           pop,
  output logic           full,
  output logic           not_empty,
  output tccc_pkg::cmd_t head
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  tccc_pkg::cmd_t entry_r [DEPTH];
  logic [AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic           do_push, do_pop;

  assign full      = (count_r == FULL_CNT);
  assign not_empty = (count_r != '0);
  assign head      = entry_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_IDX) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_IDX) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== hdl/tccc_back.sv =====
module tccc_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [31:0]    display_base,
  input  logic           q_not_empty,
  input  tccc_pkg::cmd_t q_head,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic           action,
  output logic [31:0]    bus_address,
  output logic [7:0]     write_data,
  output logic           final_res
);

  tccc_pkg::cmd_t                 cur_r, cur_nxt;
  logic [tccc_pkg::NUM_SLOTS-1:0] mask_r, mask_nxt;
  logic [tccc_pkg::NUM_SLOTS-1:0] mask_after;
  logic [2:0]                     slot_idx;
  logic                           can_emit;
  logic                           emit_act;
  logic [31:0]                    emit_ofs;
  logic [7:0]                     emit_data;

  logic        valid_r, valid_nxt;
  logic        action_r;
  logic [31:0] addr_r;
  logic [7:0]  data_r;
  logic        final_r;

  // lowest pending slot goes first
  always_comb begin
    slot_idx = '0;
    for (int i = tccc_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
      if (mask_r[i]) begin
        slot_idx = 3'(i);
      end
    end
  end

  always_comb begin
    mask_after           = mask_r;
    mask_after[slot_idx] = 1'b0;
  end

  always_comb begin
    emit_act  = tccc_pkg::ACT_WRITE;
    emit_ofs  = tccc_pkg::OFS_COL;
    emit_data = cur_r.col1;
    unique case (tccc_pkg::slot_t'(slot_idx))
      tccc_pkg::SLOT_START_POLL, tccc_pkg::SLOT_SCROLL_POLL: begin
        emit_act  = tccc_pkg::ACT_POLL;
        emit_ofs  = '0;
        emit_data = tccc_pkg::READY_STATUS;
      end
      tccc_pkg::SLOT_SCROLL: begin
        emit_ofs  = tccc_pkg::OFS_SCROLL;
        emit_data = tccc_pkg::SCROLL_DATA;
      end
      tccc_pkg::SLOT_COL1: begin
        emit_ofs  = tccc_pkg::OFS_COL;
        emit_data = cur_r.col1;
      end
      tccc_pkg::SLOT_ROW1: begin
        emit_ofs  = tccc_pkg::OFS_ROW;
        emit_data = cur_r.row1;
      end
      tccc_pkg::SLOT_CHAR: begin
        emit_ofs  = tccc_pkg::OFS_CHAR;
        emit_data = cur_r.chr;
      end
      tccc_pkg::SLOT_COL2: begin
        emit_ofs  = tccc_pkg::OFS_COL;
        emit_data = cur_r.col2;
      end
      tccc_pkg::SLOT_ROW2: begin
        emit_ofs  = tccc_pkg::OFS_ROW;
        emit_data = cur_r.row2;
      end
      default: begin
        emit_ofs  = tccc_pkg::OFS_COL;
        emit_data = cur_r.col1;
      end
    endcase
  end

  assign can_emit = (mask_r != '0) && (!valid_r || out_ready);
  // reload from the queue as the last slot leaves, no bubble
  assign q_pop    = q_not_empty && ((mask_r == '0) || (can_emit && (mask_after == '0)));

  always_comb begin
    if (q_pop) begin
      cur_nxt  = q_head;
      mask_nxt = q_head.slots;
    end else begin
      cur_nxt  = cur_r;
      mask_nxt = can_emit ? mask_after : mask_r;
    end
    if (can_emit) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    if (can_emit) begin
      action_r <= emit_act;
      addr_r   <= display_base + emit_ofs;
      data_r   <= emit_data;
      final_r  <= (mask_after == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r  <= '0;
      valid_r <= 1'b0;
    end else begin
      mask_r  <= mask_nxt;
      valid_r <= valid_nxt;
    end
  end

  assign out_valid   = valid_r;
  assign action      = action_r;
  assign bus_address = addr_r;
  assign write_data  = data_r;
  assign final_res   = final_r;

endmodule

// ===== tb/console_bus_checker.sv =====
`timescale 1ns / 100ps

module console_bus_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [tccc_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [31:0]                    cfg_wdata,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [31:0]                    in_tdata,
  input  logic                           in_tuser,
  input  logic                           in_tlast,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [39:0]                    out_tdata,
  input  logic                           out_tuser,
  input  logic                           out_tlast,
  output int                             mismatches,
  output int                             outstanding,
  output int                             transfers_checked
);

  typedef struct packed {
    logic        act;
    logic [31:0] addr;
    logic [7:0]  data;
    logic        last;
  } bus_op_t;

  logic [31:0] base_addr;
  logic [7:0]  width;
  logic [7:0]  height;
  logic [7:0]  cur_col;
  logic [7:0]  cur_row;
  bus_op_t     item_ops[$];
  bus_op_t     awaited_ops[$];
  int          lines_printed;

  task automatic report_mismatch(input string what);
    if (lines_printed < 60) $display("[%0t] mismatch: %s", $time, what);
    lines_printed++;
    mismatches++;
  endtask

  function automatic void add_write(input logic [31:0] ofs, input logic [7:0] data);
    item_ops.push_back('{tccc_pkg::ACT_WRITE, base_addr + ofs, data, 1'b0});
  endfunction

  function automatic void add_poll();
    item_ops.push_back('{tccc_pkg::ACT_POLL, base_addr, tccc_pkg::READY_STATUS, 1'b0});
  endfunction

  // Move down one line, or scroll when already on the last row.
  function automatic void next_line();
    logic [7:0] last_row;
    last_row = height - 8'd1;
    if (cur_row < last_row) begin
      cur_row = cur_row + 8'd1;
    end else begin
      add_write(tccc_pkg::OFS_SCROLL, tccc_pkg::SCROLL_DATA);
      add_poll();
    end
  endfunction

  function automatic void predict_console_item(input logic op, input logic [7:0] ch,
                                               input logic first, input logic fin,
                                               input logic [7:0] tx, input logic [7:0] ty);
    item_ops.delete();
    if (op == tccc_pkg::OP_SET) begin
      cur_col = (tx >= width) ? width - 8'd1 : tx;
      cur_row = (ty >= height) ? height - 8'd1 : ty;
      add_write(tccc_pkg::OFS_COL, cur_col);
      add_write(tccc_pkg::OFS_ROW, cur_row);
    end else begin
      if (first) add_poll();
      if (ch == tccc_pkg::CH_BACKSPACE) begin
        if (cur_col != 8'd0) begin
          cur_col = cur_col - 8'd1;
          add_write(tccc_pkg::OFS_COL, cur_col);
          add_write(tccc_pkg::OFS_CHAR, tccc_pkg::CH_BLANK);
        end
      end else if (ch == tccc_pkg::CH_NEWLINE) begin
        cur_col = 8'd0;
        next_line();
      end else if (ch != 8'h00) begin
        if (cur_col >= width) begin
          cur_col = 8'd0;
          next_line();
        end
        add_write(tccc_pkg::OFS_COL, cur_col);
        add_write(tccc_pkg::OFS_ROW, cur_row);
        add_write(tccc_pkg::OFS_CHAR, ch);
        cur_col = cur_col + 8'd1;
      end
      if (fin) begin
        add_write(tccc_pkg::OFS_COL, cur_col);
        add_write(tccc_pkg::OFS_ROW, cur_row);
      end
    end
    if (item_ops.size() > 0) item_ops[item_ops.size() - 1].last = 1'b1;
    foreach (item_ops[i]) awaited_ops.push_back(item_ops[i]);
  endfunction

  always @(posedge clk) begin
    bus_op_t seen;
    bus_op_t want;
    string   bad;
    if (!rst_n) begin
      base_addr         = 32'h0;
      width             = tccc_pkg::COLUMNS_RESET;
      height            = tccc_pkg::ROWS_RESET;
      cur_col           = 8'd0;
      cur_row           = 8'd0;
      mismatches        = 0;
      transfers_checked = 0;
      lines_printed     = 0;
      awaited_ops.delete();
    end else begin
      // Outputs are registered, so a transfer at this edge never belongs to
      // an item taken at the same edge: check first, then predict.
      if (out_tvalid && out_tready) begin
        seen = '{out_tuser, out_tdata[31:0], out_tdata[39:32], out_tlast};
        transfers_checked++;
        if (awaited_ops.size() == 0) begin
          report_mismatch($sformatf("unexpected transfer act=%0d addr=%h data=%h last=%0d",
                                    seen.act, seen.addr, seen.data, seen.last));
        end else begin
          want = awaited_ops.pop_front();
          bad  = "";
          if (seen.act !== want.act) bad = {bad, " action"};
          if (seen.addr !== want.addr) bad = {bad, " address"};
          if (seen.data !== want.data) bad = {bad, " data"};
          if (seen.last !== want.last) bad = {bad, " last"};
          if (bad != "") begin
            report_mismatch($sformatf(
              {"bad%s: got act=%0d addr=%h data=%h last=%0d,",
               " want act=%0d addr=%h data=%h last=%0d"},
              bad, seen.act, seen.addr, seen.data, seen.last,
              want.act, want.addr, want.data, want.last));
          end
        end
      end
      if (in_tvalid && in_tready) begin
        predict_console_item(in_tuser, in_tdata[7:0], in_tdata[8], in_tlast,
                             in_tdata[16:9], in_tdata[24:17]);
      end
      if (cfg_we) begin
        case (tccc_pkg::cfg_idx_t'(cfg_addr))
          tccc_pkg::CFG_BASE:    base_addr = cfg_wdata;
          tccc_pkg::CFG_COLUMNS: width     = cfg_wdata[7:0];
          tccc_pkg::CFG_ROWS:    height    = cfg_wdata[7:0];
          default: ;
        endcase
      end
    end
    outstanding <= awaited_ops.size();
  end

endmodule

// ===== tb/text_console_cursor_controller_tb.sv =====
`timescale 1ns / 100ps

module text_console_cursor_controller_tb;

  // Cycles without any transfer before the run is declared hung. Far above the
  // longest intended pause: sender gap, receiver stall pattern, or settle time.
  localparam int STALL_LIMIT = 2000;
  // Idle cycles after the last expected transfer, before the next
  // configuration write.
  localparam int SETTLE_CYCLES = 16;

  logic                           clk        = 1'b0;
  logic                           rst_n      = 1'b0;
  logic                           cfg_we     = 1'b0;
  logic [tccc_pkg::CFG_IDX_W-1:0] cfg_addr   = '0;
  logic [31:0]                    cfg_wdata  = '0;
  logic                           in_tvalid  = 1'b0;
  logic                           in_tready;
  logic [31:0]                    in_tdata   = '0;
  logic                           in_tuser   = 1'b0;
  logic                           in_tlast   = 1'b0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [39:0]                    out_tdata;
  logic                           out_tuser;
  logic                           out_tlast;

  int mismatches;
  int outstanding;
  int transfers_checked;

  int burst_left    = 0;
  int items_sent    = 0;
  int settings_used = 0;
  int quiet_cycles  = 0;

  logic [15:0] ready_pattern = 16'hFFFF;
  int          pattern_age   = 0;

  text_console_cursor_controller dut (.*);

  console_bus_checker chk (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Receiver: walk a 16-bit ready pattern, swapped for a new one whenever
  // pattern_age returns to zero. Patterns go from no stall to long stretches of stall.
  always @(posedge clk) begin
    if (pattern_age == 63) begin
      case ($urandom_range(0, 3))
        0:       ready_pattern <= 16'hFFFF;
        1:       ready_pattern <= 16'($urandom);
        2:       ready_pattern <= 16'h8421;
        default: ready_pattern <= 16'hFF00;
      endcase
      pattern_age <= 0;
    end else begin
      pattern_age <= pattern_age + 1;
    end
    out_tready <= ready_pattern[pattern_age[3:0]];
  end

  // Watchdog: end the run when no transfer moves on either side for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d results still expected",
               STALL_LIMIT, outstanding);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Present one item and hold it until the transfer. Items come in bursts of
  // random length; between bursts drop valid for a random gap (or none).
  task automatic send_item(input logic op, input logic [7:0] ch, input logic first,
                           input logic fin, input logic [7:0] tx, input logic [7:0] ty);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tlast  <= fin;
    // tdata: char_code, string_start, target_column, target_row, zero pad
    in_tdata  <= {7'h00, ty, tx, first, ch};
    do @(posedge clk); while (!in_tready);
    burst_left--;
    items_sent++;
  endtask

  // Print item; the cursor targets are don't-care, so randomize them.
  task automatic print_char(input logic [7:0] ch, input logic first, input logic fin);
    send_item(tccc_pkg::OP_PRINT, ch, first, fin, 8'($urandom), 8'($urandom));
  endtask

  // Set-cursor item; character and string flags are ignored, randomize them.
  task automatic place_cursor(input logic [7:0] tx, input logic [7:0] ty);
    send_item(tccc_pkg::OP_SET, 8'($urandom), 1'($urandom), 1'($urandom), tx, ty);
  endtask

  // Drop valid and wait until every expected result has arrived, then let the
  // block settle.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all three registers on back-to-back cycles; call only when idle.
  task automatic set_display(input logic [31:0] base, input logic [7:0] cols,
                             input logic [7:0] lines);
    cfg_we    <= 1'b1;
    cfg_addr  <= tccc_pkg::CFG_BASE;
    cfg_wdata <= base;
    @(posedge clk);
    cfg_addr  <= tccc_pkg::CFG_COLUMNS;
    cfg_wdata <= {24'h0, cols};
    @(posedge clk);
    cfg_addr  <= tccc_pkg::CFG_ROWS;
    cfg_wdata <= {24'h0, lines};
    @(posedge clk);
    cfg_we    <= 1'b0;
    settings_used++;
  endtask

  // Mostly printable text, with newlines, backspaces and any byte mixed in.
  function automatic logic [7:0] pick_char();
    case ($urandom_range(0, 9))
      0:       return tccc_pkg::CH_NEWLINE;
      1:       return tccc_pkg::CH_BACKSPACE;
      2:       return 8'($urandom);
      default: return 8'($urandom_range(32'h20, 32'h7e));
    endcase
  endfunction

  // Display size for a random phase: zero, one and full width show up often.
  function automatic logic [7:0] pick_size();
    case ($urandom_range(0, 5))
      0:       return 8'd0;
      1:       return 8'd1;
      2:       return 8'd255;
      default: return 8'($urandom_range(2, 24));
    endcase
  endfunction

  // Mostly well-formed strings (start flag on the first character, end flag on
  // the last) with random content; the rest is any item with random flags.
  task automatic run_random_phase(input int quota);
    int done;
    int len;
    int k;
    done = 0;
    while (done < quota) begin
      if ($urandom_range(0, 4) != 0) begin
        len = $urandom_range(1, 12);
        for (k = 0; k < len; k++) print_char(pick_char(), k == 0, k == len - 1);
        done += len;
      end else begin
        send_item(1'($urandom), 8'($urandom), 1'($urandom), 1'($urandom),
                  8'($urandom), 8'($urandom));
        done++;
      end
    end
  endtask

  initial begin
    int phase;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Reset size, 21 x 8 at base zero.
    print_char("H", 1'b1, 1'b0);                    // wait for ready, then the character
    print_char(tccc_pkg::CH_BACKSPACE, 1'b0, 1'b0); // step back and blank the cell
    print_char(tccc_pkg::CH_BACKSPACE, 1'b0, 1'b0); // backspace at column zero: nothing
    print_char(8'h00, 1'b0, 1'b0);                  // code zero alone: nothing
    print_char(8'h00, 1'b1, 1'b1);                  // code zero, flags still act
    print_char(tccc_pkg::CH_NEWLINE, 1'b0, 1'b1);   // move down a row
    place_cursor(8'hFF, 8'hFF);                     // clamp to the bottom right corner
    print_char(8'hFF, 1'b0, 1'b0);                  // column reaches the width
    print_char("~", 1'b1, 1'b1);                    // wrap plus scroll: eight results
    print_char(tccc_pkg::CH_NEWLINE, 1'b0, 1'b0);   // newline on the last row scrolls
    place_cursor(8'd0, 8'd0);
    print_char(8'h7F, 1'b0, 1'b1);
    wait_idle();

    // One by one display at the top of the address space: addresses wrap.
    set_display(32'hFFFF_FFFF, 8'd1, 8'd1);
    print_char("a", 1'b1, 1'b0);
    print_char("b", 1'b0, 1'b0);            // wraps and scrolls at once
    print_char(tccc_pkg::CH_NEWLINE, 1'b0, 1'b0);
    place_cursor(8'd200, 8'd200);
    print_char(tccc_pkg::CH_BACKSPACE, 1'b0, 1'b1);
    wait_idle();

    // Zero sizes: limits wrap to 255, every character wraps first.
    set_display(32'h8000_0000, 8'd0, 8'd0);
    print_char("c", 1'b0, 1'b1);            // wrap grows the row
    print_char(tccc_pkg::CH_NEWLINE, 1'b0, 1'b0);
    place_cursor(8'd9, 8'd9);               // always clamps to 255
    print_char("d", 1'b0, 1'b0);            // wrap on row 255 scrolls
    wait_idle();

    // Largest display.
    set_display($urandom, 8'd255, 8'd255);
    place_cursor(8'd254, 8'd254);
    print_char("e", 1'b0, 1'b0);
    print_char("f", 1'b0, 1'b0);            // column 255 wraps, row 254 scrolls
    print_char(tccc_pkg::CH_BACKSPACE, 1'b0, 1'b1);
    wait_idle();

    for (phase = 0; phase < 5; phase++) begin
      set_display($urandom, pick_size(), pick_size());
      run_random_phase(40);
      wait_idle();
    end

    $display("sent %0d items over %0d display settings plus reset size", items_sent,
             settings_used);
    $display("checked %0d display bus transfers, %0d mismatches", transfers_checked,
             mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
